/* rtl/core/radar_measurement_jacobian_unit_assert.svh */
// Assertion macros for the radar measurement Jacobian unit
`ifndef RADAR_MEASUREMENT_JACOBIAN_UNIT_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_UNIT_ASSERT_SVH

// same-cycle implication
`define RMJ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMJ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rmj_pkg.sv */
// Shared constants and cell payload types for the radar measurement Jacobian unit
package rmj_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [63:0] THRESH_RESET = 64'd430;
  localparam int NUM_LANES = 6;
  localparam int ROOT_W = 32;

  typedef struct packed {
    logic [63:0] x;
    logic [31:0] root;
    logic [31:0] apx;
    logic [31:0] apy;
    logic        negx;
    logic        negy;
    logic [63:0] rho2;
    logic [63:0] cmag;
    logic        cneg;
    logic        tc;
  } sq_word_t;

  typedef struct packed {
    logic [127:0] rem;
    logic [95:0]  den;
    logic [31:0]  quo;
    logic         over;
    logic         neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NUM_LANES-1:0] lane;
    logic                      tc;
  } div_word_t;

endpackage

/* rtl/core/rmj_sqrt_cell.sv */
// One root-bit cell of the square root chain
module rmj_sqrt_cell #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  rmj_pkg::sq_word_t  in_d,
  output logic               out_v,
  output rmj_pkg::sq_word_t  out_d
);

  logic [64:0] trial;
  logic        ge;
  rmj_pkg::sq_word_t nxt;

  always_comb begin
    trial = ({33'b0, in_d.root} << (K + 1)) + (65'd1 << (2 * K));
    ge = {1'b0, in_d.x} >= trial;
    nxt = in_d;
    if (ge) begin
      nxt.x = in_d.x - trial[63:0];
      nxt.root = in_d.root | (32'd1 << K);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

/* rtl/core/rmj_div_cell.sv */
// One quotient-bit cell of the six-lane divider chain
module rmj_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  rmj_pkg::div_word_t in_d,
  output logic               out_v,
  output rmj_pkg::div_word_t out_d
);

  rmj_pkg::div_word_t nxt;
  logic [127:0] sub;

  always_comb begin
    nxt = in_d;
    sub = '0;
    for (int l = 0; l < rmj_pkg::NUM_LANES; l++) begin
      sub = {32'b0, in_d.lane[l].den} << SHIFT;
      if (in_d.lane[l].rem >= sub) begin
        nxt.lane[l].rem = in_d.lane[l].rem - sub;
        nxt.lane[l].quo = in_d.lane[l].quo | (32'd1 << SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

/* rtl/core/radar_measurement_jacobian_unit.sv */
// An input beat passes stage 1, stage 2, the root chain, M1, M2, D0, the divider chain and the output register.
// Throughput: one beat per cycle while the skid is not full; the 32-cell root and divider chains are fully pipelined.
// A two-entry output (register plus skid) freezes the whole pipe only when both are full.
// Reset (rst, synchronous) clears all valid flags and sets the threshold to 430.
// Top level of the radar measurement Jacobian unit
module radar_measurement_jacobian_unit #(
  parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drange_dpx,
  output logic signed [31:0] drange_dpy,
  output logic signed [31:0] dbearing_dpx,
  output logic signed [31:0] dbearing_dpy,
  output logic signed [31:0] drate_dpx,
  output logic signed [31:0] drate_dpy,
  output logic               too_close
);

  localparam int SH_DN = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
  localparam int SH_UP = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
  localparam int NL = rmj_pkg::NUM_LANES;
  localparam int RW = rmj_pkg::ROOT_W;

  typedef struct packed {
    logic [63:0] c_lo;
    logic [63:0] c_hi;
    logic [63:0] yl;
    logic [63:0] yh;
    logic [63:0] xl;
    logic [63:0] xh;
    logic [31:0] rho;
    logic [63:0] rho2;
    logic [31:0] apx;
    logic [31:0] apy;
    logic        negx;
    logic        negy;
    logic        cnz;
    logic        cneg;
    logic        tc;
  } mul_word_t;

  typedef struct packed {
    logic [95:0] cube;
    logic [95:0] pyc;
    logic [95:0] pxc;
    logic [31:0] rho;
    logic [63:0] rho2;
    logic [31:0] apx;
    logic [31:0] apy;
    logic        negx;
    logic        negy;
    logic        cnz;
    logic        cneg;
    logic        tc;
  } sum_word_t;

  typedef struct packed {
    logic [NL-1:0][31:0] ent;
    logic                tc;
  } res_t;

  logic [63:0] min_range_squared;
  logic        en;
  logic        skid_full;
  res_t        skid_res;
  res_t        out_res;
  res_t        fin;
  logic        take;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_squared <= rmj_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      min_range_squared <= cfg_data;
    end
  end

  assign en = !skid_full;
  assign in_stall = skid_full;

  // stage 1: magnitudes, squares, cross products
  logic [31:0] ux, uy, ax_in, ay_in;
  logic        s1_v;
  logic [31:0] s1_apx, s1_apy;
  logic        s1_negx, s1_negy;
  logic [63:0] s1_apx2, s1_apy2;
  logic signed [63:0] s1_p1, s1_p2;

  assign ux = pos_x;
  assign uy = pos_y;
  assign ax_in = ux[31] ? (~ux + 32'd1) : ux;
  assign ay_in = uy[31] ? (~uy + 32'd1) : uy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_apx <= ax_in;
      s1_apy <= ay_in;
      s1_negx <= ux[31];
      s1_negy <= uy[31];
      s1_apx2 <= ax_in * ax_in;
      s1_apy2 <= ay_in * ay_in;
      s1_p1 <= vel_x * pos_y;
      s1_p2 <= vel_y * pos_x;
    end
  end

  // stage 2: squared range, cross term, threshold
  logic [63:0] rho2_c, cmag_c;
  logic        cneg_c, below_c;
  logic [64:0] thr_ceil;
  rmj_pkg::sq_word_t sq_d [RW:0];
  logic [RW:0]       sq_v;

  always_comb begin
    rho2_c = s1_apx2 + s1_apy2;
    cneg_c = s1_p1 < s1_p2;
    cmag_c = cneg_c ? 64'(s1_p2 - s1_p1) : 64'(s1_p1 - s1_p2);
    thr_ceil = {1'b0, min_range_squared >> SH_DN}
             + {64'b0, |(min_range_squared << (64 - SH_DN))};
    if (2 * FRAC_BITS <= 32) begin
      below_c = {1'b0, rho2_c} < thr_ceil;
    end else begin
      below_c = (rho2_c >> SH_UP) < min_range_squared;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[RW] <= 1'b0;
    end else if (en) begin
      sq_v[RW] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[RW].x <= rho2_c;
      sq_d[RW].root <= '0;
      sq_d[RW].apx <= s1_apx;
      sq_d[RW].apy <= s1_apy;
      sq_d[RW].negx <= s1_negx;
      sq_d[RW].negy <= s1_negy;
      sq_d[RW].rho2 <= rho2_c;
      sq_d[RW].cmag <= cmag_c;
      sq_d[RW].cneg <= cneg_c;
      sq_d[RW].tc <= (rho2_c == 64'd0) || below_c;
    end
  end

  // root chain, one bit per cell
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rmj_sqrt_cell #(.K(k)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .in_v  (sq_v[k+1]),
      .in_d  (sq_d[k+1]),
      .out_v (sq_v[k]),
      .out_d (sq_d[k])
    );
  end

  // stage M1: partial products
  mul_word_t m1;
  logic      m1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= sq_v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1.c_lo <= sq_d[0].rho2[31:0] * sq_d[0].root;
      m1.c_hi <= sq_d[0].rho2[63:32] * sq_d[0].root;
      m1.yl <= sq_d[0].apy * sq_d[0].cmag[31:0];
      m1.yh <= sq_d[0].apy * sq_d[0].cmag[63:32];
      m1.xl <= sq_d[0].apx * sq_d[0].cmag[31:0];
      m1.xh <= sq_d[0].apx * sq_d[0].cmag[63:32];
      m1.rho <= sq_d[0].root;
      m1.rho2 <= sq_d[0].rho2;
      m1.apx <= sq_d[0].apx;
      m1.apy <= sq_d[0].apy;
      m1.negx <= sq_d[0].negx;
      m1.negy <= sq_d[0].negy;
      m1.cnz <= sq_d[0].cmag != 64'd0;
      m1.cneg <= sq_d[0].cneg;
      m1.tc <= sq_d[0].tc;
    end
  end

  // stage M2: sum partial products
  sum_word_t m2;
  logic      m2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (en) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2.cube <= (96'(m1.c_hi) << 32) + 96'(m1.c_lo);
      m2.pyc <= (96'(m1.yh) << 32) + 96'(m1.yl);
      m2.pxc <= (96'(m1.xh) << 32) + 96'(m1.xl);
      m2.rho <= m1.rho;
      m2.rho2 <= m1.rho2;
      m2.apx <= m1.apx;
      m2.apy <= m1.apy;
      m2.negx <= m1.negx;
      m2.negy <= m1.negy;
      m2.cnz <= m1.cnz;
      m2.cneg <= m1.cneg;
      m2.tc <= m1.tc;
    end
  end

  // stage D0: numerators, denominators, overflow
  rmj_pkg::div_word_t dv_d [RW:0];
  logic [RW:0]        dv_v;
  rmj_pkg::div_word_t d0_c;
  logic [NL-1:0][127:0] num_c;
  logic [NL-1:0][95:0]  den_c;
  logic [NL-1:0]        neg_c;

  always_comb begin
    num_c[0] = 128'(m2.apx) << FRAC_BITS;
    den_c[0] = 96'(m2.rho);
    neg_c[0] = m2.negx;
    num_c[1] = 128'(m2.apy) << FRAC_BITS;
    den_c[1] = 96'(m2.rho);
    neg_c[1] = m2.negy;
    num_c[2] = 128'(m2.apy) << (2 * FRAC_BITS);
    den_c[2] = 96'(m2.rho2);
    neg_c[2] = !m2.negy && (m2.apy != 32'd0);
    num_c[3] = 128'(m2.apx) << (2 * FRAC_BITS);
    den_c[3] = 96'(m2.rho2);
    neg_c[3] = m2.negx;
    num_c[4] = 128'(m2.pyc) << FRAC_BITS;
    den_c[4] = m2.cube;
    neg_c[4] = m2.cnz && (m2.apy != 32'd0) && (m2.negy != m2.cneg);
    num_c[5] = 128'(m2.pxc) << FRAC_BITS;
    den_c[5] = m2.cube;
    neg_c[5] = m2.cnz && (m2.apx != 32'd0) && (m2.negx == m2.cneg);
    d0_c.tc = m2.tc;
    for (int l = 0; l < NL; l++) begin
      d0_c.lane[l].rem = num_c[l];
      d0_c.lane[l].den = den_c[l];
      d0_c.lane[l].quo = '0;
      d0_c.lane[l].over = num_c[l][127:32] >= den_c[l];
      d0_c.lane[l].neg = neg_c[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[RW] <= 1'b0;
    end else if (en) begin
      dv_v[RW] <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[RW] <= d0_c;
    end
  end

  // divider chain, one quotient bit per cell
  for (genvar s = 0; s < RW; s++) begin : g_div
    rmj_div_cell #(.SHIFT(s)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .in_v  (dv_v[s+1]),
      .in_d  (dv_d[s+1]),
      .out_v (dv_v[s]),
      .out_d (dv_d[s])
    );
  end

  // sign and saturation
  always_comb begin
    fin.tc = dv_d[0].tc;
    for (int l = 0; l < NL; l++) begin
      if (dv_d[0].tc) begin
        fin.ent[l] = '0;
      end else if (dv_d[0].lane[l].neg) begin
        if (dv_d[0].lane[l].over || dv_d[0].lane[l].quo > 32'h8000_0000) begin
          fin.ent[l] = 32'h8000_0000;
        end else begin
          fin.ent[l] = ~dv_d[0].lane[l].quo + 32'd1;
        end
      end else if (dv_d[0].lane[l].over || dv_d[0].lane[l].quo[31]) begin
        fin.ent[l] = 32'h7FFF_FFFF;
      end else begin
        fin.ent[l] = dv_d[0].lane[l].quo;
      end
    end
  end

  // output register and skid
  assign take = en && dv_v[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_res <= skid_res;
      end else if (take) begin
        out_res <= fin;
      end
    end else if (take) begin
      skid_res <= fin;
    end
  end

  assign drange_dpx = out_res.ent[0];
  assign drange_dpy = out_res.ent[1];
  assign dbearing_dpx = out_res.ent[2];
  assign dbearing_dpy = out_res.ent[3];
  assign drate_dpx = out_res.ent[4];
  assign drate_dpy = out_res.ent[5];
  assign too_close = out_res.tc;

`include "radar_measurement_jacobian_unit_assert.svh"

  `RMJ_ASSERT_IMPLIES(a_skid_has_out, clk, rst, skid_full, out_valid, "skid full without output beat")
  `RMJ_ASSERT_NEXT(a_skid_drains, clk, rst, skid_full && !out_stall, !skid_full, "skid did not drain")
  `RMJ_ASSERT_IMPLIES(a_close_zero, clk, rst, out_valid && too_close, (drange_dpx == 32'sd0) && (drange_dpy == 32'sd0) && (dbearing_dpx == 32'sd0) && (dbearing_dpy == 32'sd0) && (drate_dpx == 32'sd0) && (drate_dpy == 32'sd0), "nonzero entry on too-close beat")

endmodule
